>>> sv/lsfr_pkg.sv
// Shared types, constants and helpers for the LIN slave frame responder.
package lsfr_pkg;

  localparam logic [7:0] SYNC_BYTE     = 8'h55;
  localparam int         RESP_LEN      = 3;
  localparam int         QUEUE_DEPTH   = 6;
  localparam int         QCNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam logic [3:0] MIN_RX_LEN    = 4'd1;
  localparam logic [3:0] MAX_RX_LEN    = 4'd8;

  // Event kinds carried on the input tuser bit.
  localparam logic REQ_BREAK = 1'b0;
  localparam logic REQ_BYTE  = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_RX_FRAME_ID    = 2'd0;
  localparam logic [1:0] CFG_TX_FRAME_ID    = 2'd1;
  localparam logic [1:0] CFG_RX_DATA_LENGTH = 2'd2;

  localparam logic [5:0] RX_FRAME_ID_RST    = 6'd45;
  localparam logic [5:0] TX_FRAME_ID_RST    = 6'd44;
  localparam logic [3:0] RX_DATA_LENGTH_RST = 4'd3;
  localparam logic [7:0] RESP_FIRST_RST     = 8'd1;
  localparam logic [7:0] RESP_SECOND_RST    = 8'd2;

  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } resp_entry_t;

  // Protected ID: the six ID bits plus the two LIN parity bits.
  function automatic logic [7:0] protect_id(input logic [5:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

  // Add with end-around carry, as used by the LIN checksum.
  function automatic logic [7:0] fold_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > 9'd255) begin
      s = s - 9'd255;
    end
    return s[7:0];
  endfunction

endpackage

>>> sv/lin_slave_frame_responder_unit.sv
// LIN slave frame responder: header tracking, receive counting and response generation.
// A break or received-byte event can be accepted every cycle while in_tready is high.
// A break while idle starts a header, a sync byte 0x55 must follow, and the protected ID
// that follows either opens a receive frame of rx_data_length (clamped to 1..8) data
// bytes plus a checksum, or triggers a three-byte response (two data bytes and an
// enhanced checksum); any other ID ends the header. Response bytes leave through a
// six-entry output queue, one per cycle while out_tready is high; the input is held
// off only while the queue cannot take another full response. Configuration writes are
// applied at once and should be made while no frame is in progress.
module lin_slave_frame_responder_unit
  import lsfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // Input events
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] rx_byte
  input  logic       in_tuser,   // [0] req_type
  // Response bytes
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] tx_byte
  output logic       out_tlast,  // last_of_response
  // Configuration
  input  logic       cfg_we,
  input  logic [1:0] cfg_addr,
  input  logic [5:0] cfg_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WAIT_SYNC,
    ST_WAIT_PID,
    ST_RECEIVE
  } frame_state_t;

  frame_state_t state_r, state_nxt;
  logic        break_en_r, break_en_nxt;
  logic [3:0]  data_cnt_r, data_cnt_nxt;
  logic [7:0]  resp_first_r, resp_first_nxt;
  logic [7:0]  resp_second_r, resp_second_nxt;
  logic [5:0]  rx_id_r;
  logic [5:0]  tx_id_r;
  logic [3:0]  rx_len_r;

  resp_entry_t         q_r   [QUEUE_DEPTH];
  resp_entry_t         q_nxt [QUEUE_DEPTH];
  logic [QCNT_W-1:0]   q_cnt_r, q_cnt_nxt;
  logic [QCNT_W-1:0]   q_base;

  logic       in_acc;
  logic       out_acc;
  logic       resp_push;
  logic [7:0] rx_pid;
  logic [7:0] tx_pid;
  logic [7:0] sum1;
  logic [7:0] chk;
  logic [3:0] len_eff;
  logic [3:0] cnt_inc;

  assign in_tready  = (q_cnt_r <= QCNT_W'(QUEUE_DEPTH - RESP_LEN)) ||
                      ((q_cnt_r == QCNT_W'(QUEUE_DEPTH - RESP_LEN + 1)) && out_tready);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = (q_cnt_r != '0);
  assign out_acc    = out_tvalid && out_tready;
  assign out_tdata  = q_r[0].data;
  assign out_tlast  = q_r[0].last;

  assign rx_pid  = protect_id(rx_id_r);
  assign tx_pid  = protect_id(tx_id_r);
  assign sum1    = fold_add(in_tdata, resp_first_r);
  assign chk     = ~fold_add(sum1, resp_second_r);
  assign cnt_inc = data_cnt_r + 4'd1;

  always_comb begin
    if (rx_len_r < MIN_RX_LEN) begin
      len_eff = MIN_RX_LEN;
    end else if (rx_len_r > MAX_RX_LEN) begin
      len_eff = MAX_RX_LEN;
    end else begin
      len_eff = rx_len_r;
    end
  end

  // Frame state machine, evaluated once per accepted event.
  always_comb begin
    state_nxt       = state_r;
    break_en_nxt    = break_en_r;
    data_cnt_nxt    = data_cnt_r;
    resp_first_nxt  = resp_first_r;
    resp_second_nxt = resp_second_r;
    resp_push       = 1'b0;
    if (in_acc) begin
      if (in_tuser == REQ_BREAK) begin
        if (break_en_r) begin
          state_nxt    = ST_WAIT_SYNC;
          data_cnt_nxt = '0;
          break_en_nxt = 1'b0;
        end
      end else begin
        case (state_r)
          ST_WAIT_SYNC: begin
            if (in_tdata == SYNC_BYTE) begin
              state_nxt = ST_WAIT_PID;
            end else begin
              state_nxt    = ST_IDLE;
              break_en_nxt = 1'b1;
            end
          end
          ST_WAIT_PID: begin
            if (in_tdata == rx_pid) begin
              state_nxt    = ST_RECEIVE;
              data_cnt_nxt = '0;
            end else if (in_tdata == tx_pid) begin
              resp_push       = 1'b1;
              resp_first_nxt  = resp_first_r + 8'd1;
              resp_second_nxt = resp_second_r + 8'd1;
              data_cnt_nxt    = '0;
              state_nxt       = ST_IDLE;
              break_en_nxt    = 1'b1;
            end else begin
              state_nxt    = ST_IDLE;
              break_en_nxt = 1'b1;
            end
          end
          ST_RECEIVE: begin
            data_cnt_nxt = cnt_inc;
            // The frame ends after the data bytes and the checksum byte.
            if ({1'b0, cnt_inc} >= ({1'b0, len_eff} + 5'd1)) begin
              data_cnt_nxt = '0;
              state_nxt    = ST_IDLE;
              break_en_nxt = 1'b1;
            end
          end
          default: begin
            state_nxt = state_r;
          end
        endcase
      end
    end
  end

  // Output queue: shift toward the head on a pop, append a response at the tail.
  always_comb begin
    q_base = q_cnt_r - QCNT_W'(out_acc);
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (out_acc && (i < QUEUE_DEPTH - 1)) begin
        q_nxt[i] = q_r[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if (resp_push) begin
        if (q_base == QCNT_W'(i)) begin
          q_nxt[i] = '{last: 1'b0, data: resp_first_r};
        end else if (q_base + QCNT_W'(1) == QCNT_W'(i)) begin
          q_nxt[i] = '{last: 1'b0, data: resp_second_r};
        end else if (q_base + QCNT_W'(2) == QCNT_W'(i)) begin
          q_nxt[i] = '{last: 1'b1, data: chk};
        end
      end
    end
    q_cnt_nxt = q_base + (resp_push ? QCNT_W'(RESP_LEN) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      break_en_r    <= 1'b1;
      data_cnt_r    <= '0;
      resp_first_r  <= RESP_FIRST_RST;
      resp_second_r <= RESP_SECOND_RST;
      q_cnt_r       <= '0;
    end else begin
      state_r       <= state_nxt;
      break_en_r    <= break_en_nxt;
      data_cnt_r    <= data_cnt_nxt;
      resp_first_r  <= resp_first_nxt;
      resp_second_r <= resp_second_nxt;
      q_cnt_r       <= q_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_id_r  <= RX_FRAME_ID_RST;
      tx_id_r  <= TX_FRAME_ID_RST;
      rx_len_r <= RX_DATA_LENGTH_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_RX_FRAME_ID:    rx_id_r  <= cfg_wdata;
        CFG_TX_FRAME_ID:    tx_id_r  <= cfg_wdata;
        CFG_RX_DATA_LENGTH: rx_len_r <= cfg_wdata[3:0];
        default: begin
          rx_len_r <= rx_len_r;
        end
      endcase
    end
  end

  // Break detection is armed exactly when no header or frame is in progress.
  a_break_en_idle: assert property (@(posedge clk) disable iff (!rst_n)
    break_en_r == (state_r == ST_IDLE))
    else $error("break enable out of step with frame state");

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("output queue overflow");

  a_q_count: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ({1'b0, q_cnt_r} == {1'b0, $past(q_cnt_r)}
                      + ($past(resp_push) ? (QCNT_W + 1)'(RESP_LEN) : '0)
                      - (QCNT_W + 1)'($past(out_acc))))
    else $error("output queue count mismatch");

  a_data_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    data_cnt_r <= MAX_RX_LEN)
    else $error("receive byte count out of range");

endmodule
